// ===== rtl/core/afr_pkg.sv =====
// package for the accessory packet framer
// payload types, register indexes, constants and the checksum function
`timescale 1ns / 1ps

package afr_pkg;

  localparam int unsigned MaxPayload  = 251;
  localparam int unsigned LenOverhead = 4;
  localparam int unsigned BurstMax    = 8;

  typedef enum logic [1:0] {
    REG_SYNC  = 2'd0,
    REG_START = 2'd1,
    REG_LINGO = 2'd2,
    REG_NONE  = 2'd3
  } reg_idx_t;

  typedef enum logic {
    REQ_HEADER = 1'b0,
    REQ_DATA   = 1'b1
  } req_type_t;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  command_id;
    logic [15:0] trans_id;
    logic [7:0]  data_len;
    logic [7:0]  payload_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } result_t;

  typedef struct packed {
    logic [7:0] sync_value;
    logic [7:0] start_value;
    logic [7:0] lingo_value;
  } cfg_t;

  // bytes produced by one input transaction, element 0 goes out first
  typedef struct packed {
    logic [BurstMax-1:0][7:0] bytes;
    logic [3:0]               count;
    logic                     end_last;
  } burst_t;

  function automatic logic [7:0] checksum_of(input logic [7:0] s);
    return (s ^ 8'hFF) + 8'h01;
  endfunction

endpackage

// ===== rtl/core/afr_stream_if.sv =====
// valid/ready channel carrying one payload struct
// depends on nothing, payload type comes in as a parameter
`timescale 1ns / 1ps

interface afr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/afr_framer.sv =====
// configuration registers, packet state and byte burst builder
// depends on afr_pkg
`timescale 1ns / 1ps

module afr_framer import afr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [7:0] cfg_data,
  input  logic       accept,
  input  item_t      item,
  output burst_t     burst
);

  cfg_t       cfg;
  logic [7:0] sum_acc;
  logic [7:0] bytes_left;
  logic       in_packet;

  logic [7:0] sum_acc_next;
  logic [7:0] bytes_left_next;
  logic       in_packet_next;

  logic [7:0] len;
  logic [7:0] lbyte;
  logic [7:0] hsum;
  logic [7:0] dsum;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_value  <= 8'd255;
      cfg.start_value <= 8'd85;
      cfg.lingo_value <= 8'd0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_SYNC:  cfg.sync_value  <= cfg_data;
        REG_START: cfg.start_value <= cfg_data;
        REG_LINGO: cfg.lingo_value <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    len   = (item.data_len > 8'(MaxPayload)) ? 8'(MaxPayload) : item.data_len;
    lbyte = len + 8'(LenOverhead);
    hsum  = lbyte + cfg.lingo_value + item.command_id
          + item.trans_id[15:8] + item.trans_id[7:0];
    dsum  = sum_acc + item.payload_byte;

    burst           = '0;
    sum_acc_next    = sum_acc;
    bytes_left_next = bytes_left;
    in_packet_next  = in_packet;

    if (item.req_type == REQ_HEADER) begin
      burst.bytes[0] = cfg.sync_value;
      burst.bytes[1] = cfg.start_value;
      burst.bytes[2] = lbyte;
      burst.bytes[3] = cfg.lingo_value;
      burst.bytes[4] = item.command_id;
      burst.bytes[5] = item.trans_id[15:8];
      burst.bytes[6] = item.trans_id[7:0];
      burst.bytes[7] = checksum_of(hsum);
      burst.end_last = (len == 8'd0);
      burst.count    = (len == 8'd0) ? 4'd8 : 4'd7;
      sum_acc_next    = hsum;
      bytes_left_next = len;
      in_packet_next  = (len != 8'd0);
    end else if (in_packet) begin
      // last expected byte closes the packet with its checksum
      burst.bytes[0]  = item.payload_byte;
      burst.bytes[1]  = checksum_of(dsum);
      burst.end_last  = (bytes_left <= 8'd1);
      burst.count     = (bytes_left <= 8'd1) ? 4'd2 : 4'd1;
      sum_acc_next    = dsum;
      bytes_left_next = (bytes_left != 8'd0) ? bytes_left - 8'd1 : 8'd0;
      in_packet_next  = (bytes_left > 8'd1);
    end
    // stray payload leaves count at zero and is dropped
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_acc    <= '0;
      bytes_left <= '0;
      in_packet  <= 1'b0;
    end else if (accept) begin
      sum_acc    <= sum_acc_next;
      bytes_left <= bytes_left_next;
      in_packet  <= in_packet_next;
    end
  end

endmodule

// ===== rtl/core/afr_serializer.sv =====
// burst register that hands out one byte per output transaction
// depends on afr_pkg
`timescale 1ns / 1ps

module afr_serializer import afr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  burst_t  burst,
  output logic    can_load,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  burst_t     held;
  logic [2:0] idx;
  logic [3:0] rem;

  // take a new burst when empty or when the last byte leaves this cycle
  assign can_load  = (rem == 4'd0) || (rem == 4'd1 && out_ready);
  assign out_valid = (rem != 4'd0);
  assign out_data.out_byte  = held.bytes[idx];
  assign out_data.frame_end = (rem == 4'd1) && held.end_last;

  always_ff @(posedge clk) begin
    if (load) begin
      held <= burst;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      rem <= '0;
    end else if (load) begin
      idx <= '0;
      rem <= burst.count;
    end else if (out_valid && out_ready) begin
      idx <= idx + 3'd1;
      rem <= rem - 4'd1;
    end
  end

endmodule

// ===== rtl/core/accessory_packet_framer_core.sv =====
// latency: first byte of a transaction appears the cycle after it is accepted
// throughput: a transaction is taken as the last byte of the one before leaves;
//   a payload byte passes every cycle while the output is ready, a header or
//   closing byte holds the input until its burst is out (burst register, byte counter)
// reset: synchronous, clears packet state, burst counter and loads register defaults
// top level of the packet framer, depends on afr_pkg, afr_stream_if,
// afr_framer and afr_serializer
`timescale 1ns / 1ps

module accessory_packet_framer_core import afr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  afr_stream_if.sink   item,
  afr_stream_if.source result,
  input  logic       cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [7:0] cfg_data
);

  burst_t  burst;
  logic    can_load;
  logic    accept;
  result_t res;

  assign item.ready = can_load;
  assign accept     = item.valid && can_load;

  afr_framer u_framer (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .accept   (accept),
    .item     (item.data),
    .burst    (burst)
  );

  afr_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .burst     (burst),
    .can_load  (can_load),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (res)
  );

  assign result.data = res;

endmodule

// ===== rtl/core/afr_checker.sv =====
// port level checks for the packet framer, bound to the top level
// depends on afr_pkg
`timescale 1ns / 1ps

module afr_checker import afr_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_ready,
  input logic    item_type,
  input logic    res_valid,
  input logic    res_ready,
  input result_t res_data
);

  // a stalled result stays put
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // input must wait while a stalled byte is pending
  a_no_accept_stall: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !item_ready)
    else $error("input ready while output stalled");

  // a header always starts with a non-closing sync byte
  a_header_start: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item_type == REQ_HEADER
    |=> res_valid && !res_data.frame_end)
    else $error("header did not start a packet");

endmodule

bind accessory_packet_framer_core afr_checker u_afr_checker (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item.valid),
  .item_ready (item.ready),
  .item_type  (item.data.req_type),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_data   (result.data)
);

// ===== test/accessory_packet_framer_core_tb.sv =====
// testbench for accessory_packet_framer_core: directed and random packets against a byte predictor
// depends on afr_pkg, afr_stream_if and the framer rtl
`timescale 1ns / 1ps

module accessory_packet_framer_core_tb;
  import afr_pkg::*;

  localparam int StallLimit = 2000;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_idx;
  logic [7:0] cfg_data;

  afr_stream_if #(.payload_t(item_t))   item_if ();
  afr_stream_if #(.payload_t(result_t)) result_if ();

  accessory_packet_framer_core dut (
    .clk      (clk),
    .rst      (rst),
    .item     (item_if),
    .result   (result_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // predictor state and register copy
  cfg_t       cfg_shadow;
  logic [7:0] run_sum;
  logic [7:0] bytes_due;
  logic       pkt_open;
  result_t    expected_bytes[$];

  int unsigned framed_count;
  int unsigned sent_count;
  int unsigned checked_bytes;
  int unsigned closed_frames;
  int unsigned cfg_writes;
  int unsigned error_count;
  int unsigned burst_left;
  int unsigned hold_cycles;
  int unsigned idle_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void add_byte(input logic [7:0] b, input logic last);
    result_t r;
    r.out_byte  = b;
    r.frame_end = last;
    expected_bytes.push_back(r);
  endfunction

  // returns the number of bytes this transaction adds to the packet stream
  function automatic int frame_item(input item_t it);
    logic [7:0] len;
    int         before_cnt;
    before_cnt = expected_bytes.size();
    if (it.req_type == REQ_HEADER) begin
      len = (it.data_len > 8'(MaxPayload)) ? 8'(MaxPayload) : it.data_len;
      add_byte(cfg_shadow.sync_value, 1'b0);
      add_byte(cfg_shadow.start_value, 1'b0);
      add_byte(len + 8'(LenOverhead), 1'b0);
      add_byte(cfg_shadow.lingo_value, 1'b0);
      add_byte(it.command_id, 1'b0);
      add_byte(it.trans_id[15:8], 1'b0);
      add_byte(it.trans_id[7:0], 1'b0);
      run_sum = len + 8'(LenOverhead) + cfg_shadow.lingo_value + it.command_id
              + it.trans_id[15:8] + it.trans_id[7:0];
      bytes_due = len;
      if (len == 8'd0) begin
        add_byte(8'd0 - run_sum, 1'b1);
        pkt_open = 1'b0;
      end else begin
        pkt_open = 1'b1;
      end
    end else if (pkt_open) begin
      add_byte(it.payload_byte, 1'b0);
      run_sum = run_sum + it.payload_byte;
      if (bytes_due != 8'd0) bytes_due = bytes_due - 8'd1;
      if (bytes_due == 8'd0) begin
        add_byte(8'd0 - run_sum, 1'b1);
        pkt_open = 1'b0;
      end
    end
    return expected_bytes.size() - before_cnt;
  endfunction

  function automatic item_t random_item();
    item_t it;
    it.req_type     = 1'($urandom_range(0, 1));
    it.command_id   = 8'($urandom_range(0, 255));
    it.trans_id     = 16'($urandom_range(0, 65535));
    it.data_len     = 8'($urandom_range(0, 255));
    it.payload_byte = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // unused fields stay random so the block has to ignore them
  function automatic item_t make_header(input logic [7:0] cmd, input logic [15:0] tid,
                                        input logic [7:0] len);
    item_t it;
    it            = random_item();
    it.req_type   = REQ_HEADER;
    it.command_id = cmd;
    it.trans_id   = tid;
    it.data_len   = len;
    return it;
  endfunction

  function automatic item_t make_data(input logic [7:0] b);
    item_t it;
    it              = random_item();
    it.req_type     = REQ_DATA;
    it.payload_byte = b;
    return it;
  endfunction

  task automatic send_item(input item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      repeat ($urandom_range(1, 9)) begin
        @(negedge clk);
        item_if.valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    item_if.valid <= 1'b1;
    item_if.data  <= it;
    do @(posedge clk); while (!item_if.ready);
    sent_count++;
    if (frame_item(it) != 0) framed_count++;
  endtask

  task automatic send_packet(input logic [7:0] len, input int unsigned n_data);
    send_item(make_header(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), len));
    repeat (n_data) send_item(make_data(8'($urandom_range(0, 255))));
  endtask

  // stray payload leaves nothing to wait for, so the wait runs on past the last expected byte
  task automatic drain;
    @(negedge clk);
    item_if.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [7:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SYNC:  cfg_shadow.sync_value  = value;
      REG_START: cfg_shadow.start_value = value;
      REG_LINGO: cfg_shadow.lingo_value = value;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic test_reset_defaults;
    send_item(make_header(8'h00, 16'h0000, 8'd0));
    send_item(make_header(8'hFF, 16'hFFFF, 8'd0));
    send_item(make_header(8'h5A, 16'h8001, 8'd1));
    send_item(make_data(8'hFF));
    drain();
  endtask

  task automatic test_stray_and_unused;
    send_item(make_data(8'h00));
    send_item(make_data(8'hFF));
    send_item(make_header(8'h12, 16'h3456, 8'd2));
    send_item(make_data(8'h80));
    send_item(make_data(8'h7F));
    send_item(make_data(8'h33));
    drain();
  endtask

  task automatic test_oversize_and_restart;
    send_item(make_header(8'hC3, 16'h00FF, 8'd255));
    send_item(make_data(8'h01));
    send_item(make_data(8'hFE));
    // a header inside an open packet drops it without a checksum
    send_item(make_header(8'h3C, 16'hFF00, 8'd252));
    send_item(make_header(8'h01, 16'h1234, 8'd251));
    send_item(make_data(8'hAA));
    send_item(make_header(8'h02, 16'hABCD, 8'd3));
    send_item(make_data(8'h55));
    send_item(make_header(8'h03, 16'h0F0F, 8'd1));
    send_item(make_data(8'h10));
    drain();
  endtask

  task automatic test_registers;
    write_reg(REG_NONE, 8'hA5);
    send_item(make_header(8'h44, 16'h2211, 8'd0));
    drain();
    write_reg(REG_SYNC, 8'h00);
    write_reg(REG_START, 8'h00);
    write_reg(REG_LINGO, 8'h00);
    send_item(make_header(8'h00, 16'h0000, 8'd1));
    send_item(make_data(8'h00));
    drain();
    write_reg(REG_SYNC, 8'hFF);
    write_reg(REG_START, 8'hFF);
    write_reg(REG_LINGO, 8'hFF);
    send_item(make_header(8'hFF, 16'hFFFF, 8'd2));
    send_item(make_data(8'hFF));
    send_item(make_data(8'hFF));
    drain();
  endtask

  task automatic test_longest_packet;
    // any oversize length saturates to the full payload
    send_packet(8'($urandom_range(252, 255)), MaxPayload);
    drain();
  endtask

  task automatic test_backpressure;
    hold_cycles = 300;
    burst_left  = 60;
    send_packet(8'd20, 20);
    drain();
  endtask

  task automatic test_random_traffic(input int unsigned goal);
    int unsigned pick;
    int unsigned len;
    int unsigned n_data;
    int unsigned start_cnt;
    start_cnt = framed_count;
    while (framed_count - start_cnt < goal) begin
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        len    = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
        n_data = len;
        // possibly a broken packet, cut short at a random point, left for later items to restart
        if ($urandom_range(0, 9) == 0) n_data = $urandom_range(0, len);
        send_packet(8'(len), n_data);
      end else if (pick == 8) begin
        repeat ($urandom_range(1, 3)) send_item(make_data(8'($urandom_range(0, 255))));
      end else begin
        send_item(random_item());
      end
    end
    drain();
  endtask

  task automatic random_registers;
    write_reg(REG_SYNC, 8'($urandom_range(0, 255)));
    write_reg(REG_START, 8'($urandom_range(0, 255)));
    write_reg(REG_LINGO, 8'($urandom_range(0, 255)));
    write_reg(REG_NONE, 8'($urandom_range(0, 255)));
  endtask

  // receiver: modes of its own, plus a long hold-off on request
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    result_if.ready = 1'b0;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles != 0) begin
        result_if.ready <= 1'b0;
        hold_cycles--;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 80);
        end
        mode_left--;
        case (mode)
          0:       result_if.ready <= 1'b1;
          1:       result_if.ready <= ($urandom_range(0, 2) != 0);
          default: result_if.ready <= (mode_left[1:0] != 2'd0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      checked_bytes <= checked_bytes + 1;
      if (expected_bytes.size() == 0) begin
        error_count++;
        $display("%0t: unexpected byte %h frame_end %b", $time,
                 result_if.data.out_byte, result_if.data.frame_end);
      end else begin
        want = expected_bytes.pop_front();
        if (want.frame_end) closed_frames <= closed_frames + 1;
        if (result_if.data.out_byte !== want.out_byte) begin
          error_count++;
          $display("%0t: out_byte expected %h actual %h", $time,
                   want.out_byte, result_if.data.out_byte);
        end
        if (result_if.data.frame_end !== want.frame_end) begin
          error_count++;
          $display("%0t: frame_end expected %b actual %b", $time,
                   want.frame_end, result_if.data.frame_end);
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_idx       = REG_SYNC;
    cfg_data      = 8'd0;
    item_if.valid = 1'b0;
    item_if.data  = '0;
    cfg_shadow    = '{sync_value: 8'd255, start_value: 8'd85, lingo_value: 8'd0};
    run_sum       = 8'd0;
    bytes_due     = 8'd0;
    pkt_open      = 1'b0;
    framed_count  = 0;
    sent_count    = 0;
    checked_bytes = 0;
    closed_frames = 0;
    cfg_writes    = 0;
    error_count   = 0;
    burst_left    = 0;
    hold_cycles   = 0;
    idle_cycles   = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_stray_and_unused();
    test_oversize_and_restart();
    test_registers();
    test_longest_packet();
    test_backpressure();
    random_registers();
    test_random_traffic(3);
    random_registers();
    test_random_traffic(3);
    random_registers();
    test_random_traffic(3);

    @(negedge clk);
    item_if.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("tb: %0d input transactions (%0d framed), %0d bytes checked, %0d packets closed",
             sent_count, framed_count, checked_bytes, closed_frames);
    $display("tb: %0d register writes incl. extremes and an unmapped index, one long hold-off",
             cfg_writes);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
